// ----- hdl/pkd_pkg.sv -----
// ----------------------------------------------------------------------------
// pkd_pkg
// Shared types and constants of the prompt keyword detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pkd_pkg;

  // default store depths
  localparam int HISTORY_BYTES_DEF = 64;
  localparam int PATTERN_BYTES_DEF = 64;

  // line terminators
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_NUL = 8'h00;

  // command codes on the input tuser
  typedef enum logic [2:0] {
    OP_RX    = 3'd0,
    OP_HALTW = 3'd1,
    OP_WAITW = 3'd2,
    OP_CLEAR = 3'd3,
    OP_START = 3'd4,
    OP_STOP  = 3'd5,
    OP_ARM   = 3'd6
  } op_t;

  // keyword list select
  typedef enum logic {
    LIST_HALT = 1'b0,
    LIST_WAIT = 1'b1
  } list_t;

  // top level sequencer
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_CHECK = 2'd1,
    S_HSCAN = 2'd2,
    S_WSCAN = 2'd3
  } st_t;

  // scan request and response between sequencer and match unit
  typedef struct packed {
    logic  start;
    list_t sel;
  } scan_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } scan_rsp_t;

endpackage

`default_nettype wire

// ----- hdl/pkd_hist.sv -----
// ----------------------------------------------------------------------------
// pkd_hist
// Ring buffer of the current line; read by offset back from the newest byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pkd_hist #(
  parameter int HISTORY_BYTES = 64,
  parameter int PATTERN_BYTES = 64
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               wr_en,
  input  wire  [7:0]                        wr_byte,
  input  wire  [$clog2(PATTERN_BYTES)-1:0]  rd_off,
  output logic [7:0]                        rd_q,
  output logic                              rd_ok
);
  import pkd_pkg::*;

  localparam int HW = $clog2(HISTORY_BYTES);
  localparam int CW = $clog2(HISTORY_BYTES + 1);
  localparam int PW = $clog2(PATTERN_BYTES);
  localparam int AW = ((HW > PW) ? HW : PW) + 2;

  logic [7:0]    mem [HISTORY_BYTES];
  logic [HW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          line_end;
  logic [AW-1:0] pos;
  logic          ok_c;
  logic [HW-1:0] rd_idx;

  assign line_end = (wr_byte == CH_LF) || (wr_byte == CH_CR) || (wr_byte == CH_NUL);

  // head and count update
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (wr_en) begin
      if (line_end) begin
        count_nxt = '0;
      end else begin
        head_nxt = (head_r == HW'(HISTORY_BYTES - 1)) ? '0 : head_r + HW'(1);
        if (count_r != CW'(HISTORY_BYTES)) begin
          count_nxt = count_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // offset back from newest byte -> ring index
  always_comb begin
    ok_c = AW'(rd_off) < AW'(count_r);
    pos  = AW'(head_r) + AW'(HISTORY_BYTES - 1) - AW'(rd_off);
    if (pos >= AW'(HISTORY_BYTES)) begin
      pos = pos - AW'(HISTORY_BYTES);
    end
    rd_idx = ok_c ? pos[HW-1:0] : '0;
  end

  // line memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en && !line_end) begin
      mem[head_r] <= wr_byte;
    end
    rd_q  <= mem[rd_idx];
    rd_ok <= ok_c;
  end

endmodule

`default_nettype wire

// ----- hdl/pkd_patt.sv -----
// ----------------------------------------------------------------------------
// pkd_patt
// Halt and wait keyword lists: append-only memories with fill counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pkd_patt #(
  parameter int PATTERN_BYTES = 64
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 wr_en,
  input  pkd_pkg::list_t                      wr_sel,
  input  wire  [7:0]                          wr_byte,
  input  wire                                 wr_start,
  input  wire                                 clear,
  input  pkd_pkg::list_t                      rd_sel,
  input  wire  [$clog2(PATTERN_BYTES)-1:0]    rd_addr,
  output logic [8:0]                          rd_q,
  output logic [$clog2(PATTERN_BYTES+1)-1:0]  halt_len,
  output logic [$clog2(PATTERN_BYTES+1)-1:0]  wait_len,
  output logic                                halt_full,
  output logic                                wait_full
);
  import pkd_pkg::*;

  localparam int IW = $clog2(PATTERN_BYTES);
  localparam int LW = $clog2(PATTERN_BYTES + 1);

  logic [8:0]    halt_mem [PATTERN_BYTES];
  logic [8:0]    wait_mem [PATTERN_BYTES];
  logic [LW-1:0] halt_len_r, halt_len_nxt;
  logic [LW-1:0] wait_len_r, wait_len_nxt;
  logic          halt_we, wait_we;
  logic [8:0]    halt_q, wait_q;
  list_t         sel_q;

  assign halt_full = (halt_len_r == LW'(PATTERN_BYTES));
  assign wait_full = (wait_len_r == LW'(PATTERN_BYTES));
  assign halt_we   = wr_en && (wr_sel == LIST_HALT) && !halt_full;
  assign wait_we   = wr_en && (wr_sel == LIST_WAIT) && !wait_full;
  assign halt_len  = halt_len_r;
  assign wait_len  = wait_len_r;

  // fill counts
  always_comb begin
    halt_len_nxt = halt_len_r;
    wait_len_nxt = wait_len_r;
    if (clear) begin
      halt_len_nxt = '0;
      wait_len_nxt = '0;
    end else begin
      if (halt_we) halt_len_nxt = halt_len_r + LW'(1);
      if (wait_we) wait_len_nxt = wait_len_r + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halt_len_r <= '0;
      wait_len_r <= '0;
    end else begin
      halt_len_r <= halt_len_nxt;
      wait_len_r <= wait_len_nxt;
    end
  end

  // list memories; bit 8 marks the first byte of a word
  always_ff @(posedge clk) begin
    if (halt_we) begin
      halt_mem[halt_len_r[IW-1:0]] <= {wr_start, wr_byte};
    end
    halt_q <= halt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wait_we) begin
      wait_mem[wait_len_r[IW-1:0]] <= {wr_start, wr_byte};
    end
    wait_q <= wait_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    sel_q <= rd_sel;
  end

  assign rd_q = (sel_q == LIST_WAIT) ? wait_q : halt_q;

endmodule

`default_nettype wire

// ----- hdl/pkd_match.sv -----
// ----------------------------------------------------------------------------
// pkd_match
// Suffix matcher: walks one keyword list from its last byte down, one byte
// compare per cycle against the line tail.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pkd_match #(
  parameter int PATTERN_BYTES = 64
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  pkd_pkg::scan_req_t                  req,
  input  wire  [$clog2(PATTERN_BYTES+1)-1:0]  len,
  input  wire  [8:0]                          pat_q,
  input  wire  [7:0]                          hist_q,
  input  wire                                 hist_ok,
  output pkd_pkg::list_t                      pat_sel,
  output logic [$clog2(PATTERN_BYTES)-1:0]    pat_addr,
  output logic [$clog2(PATTERN_BYTES)-1:0]    hist_off,
  output pkd_pkg::scan_rsp_t                  rsp
);
  import pkd_pkg::*;

  localparam int IW = $clog2(PATTERN_BYTES);
  localparam int LW = $clog2(PATTERN_BYTES + 1);

  list_t         sel_r, sel_nxt;
  logic          iss_act_r, iss_act_nxt;
  logic [IW-1:0] iss_k_r, iss_k_nxt;
  logic          first_r, first_nxt;
  logic          cmp_v_r, cmp_v_nxt;
  logic [IW-1:0] cmp_j_r, cmp_j_nxt;
  logic          cmp_last_r, cmp_last_nxt;
  logic          bad_r, bad_nxt;
  logic [IW-1:0] j_iss;
  logic          byte_ok, word_bad, word_end;

  // tail offset of the entry being issued: restarts after a word start
  assign j_iss    = (first_r || pat_q[8]) ? '0 : cmp_j_r + IW'(1);
  assign pat_addr = iss_k_r;
  assign hist_off = j_iss;
  assign pat_sel  = sel_r;

  // shared byte compare
  assign byte_ok  = (pat_q[7:0] == hist_q) && hist_ok;
  assign word_bad = bad_r || !byte_ok;
  assign word_end = pat_q[8] || cmp_last_r;

  always_comb begin
    rsp.hit  = cmp_v_r && word_end && !word_bad;
    rsp.done = cmp_v_r && (rsp.hit || cmp_last_r);
  end

  // sequencer
  always_comb begin
    sel_nxt      = sel_r;
    iss_act_nxt  = iss_act_r;
    iss_k_nxt    = iss_k_r;
    first_nxt    = first_r;
    cmp_v_nxt    = 1'b0;
    cmp_j_nxt    = cmp_j_r;
    cmp_last_nxt = cmp_last_r;
    bad_nxt      = bad_r;
    if (req.start) begin
      sel_nxt     = req.sel;
      iss_act_nxt = 1'b1;
      iss_k_nxt   = IW'(len - LW'(1));
      first_nxt   = 1'b1;
      bad_nxt     = 1'b0;
    end else if (rsp.done) begin
      iss_act_nxt = 1'b0;
    end else begin
      if (iss_act_r) begin
        cmp_v_nxt    = 1'b1;
        cmp_j_nxt    = j_iss;
        cmp_last_nxt = (iss_k_r == '0);
        iss_act_nxt  = (iss_k_r != '0);
        iss_k_nxt    = iss_k_r - IW'(1);
        first_nxt    = 1'b0;
      end
      if (cmp_v_r) begin
        bad_nxt = word_end ? 1'b0 : word_bad;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_act_r <= 1'b0;
      cmp_v_r   <= 1'b0;
      first_r   <= 1'b0;
      bad_r     <= 1'b0;
      sel_r     <= LIST_HALT;
    end else begin
      iss_act_r <= iss_act_nxt;
      cmp_v_r   <= cmp_v_nxt;
      first_r   <= first_nxt;
      bad_r     <= bad_nxt;
      sel_r     <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_k_r    <= iss_k_nxt;
    cmp_j_r    <= cmp_j_nxt;
    cmp_last_r <= cmp_last_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/prompt_keyword_detector_unit.sv -----
// ----------------------------------------------------------------------------
// prompt_keyword_detector_unit
// Terminal stream keyword detector with halt and wait keyword lists.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : command words; tuser = opcode, tdata = data byte and word start.
//   out_* : one result word per command: halted, proceed, list_full.
//   cfg_* : write of wait_enable, taken at any cycle (write only when idle).
// Timing:
//   Non-receive commands load their result word at acceptance; it is valid
//   in the next cycle. A received byte is stored at acceptance, then the
//   halt list and, when needed, the wait list are scanned by one byte
//   comparator, one list byte per cycle; a hit ends a scan early. The
//   comparator and the single read port of each list memory set this rate.
//   in_tready is low while a byte is being checked, and also while the
//   result word is held and not yet taken.
// Reset:
//   Synchronous, active low: line empty, both lists empty, not running,
//   not waiting, wait_enable cleared. Memories are not cleared.
// Stall:
//   A result word holds on out_tdata until out_tready; no word is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prompt_keyword_detector_unit #(
  parameter int HISTORY_BYTES = pkd_pkg::HISTORY_BYTES_DEF,
  parameter int PATTERN_BYTES = pkd_pkg::PATTERN_BYTES_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // [7:0] data_byte, [8] word_start
  input  wire  [2:0]  in_tuser,   // [2:0] opcode
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // [0] halted, [1] proceed, [2] list_full
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire         cfg_data
);
  import pkd_pkg::*;

  localparam int IW = $clog2(PATTERN_BYTES);
  localparam int LW = $clog2(PATTERN_BYTES + 1);

  st_t           state_r, state_nxt;
  logic          running_r, running_nxt;
  logic          waiting_r, waiting_nxt;
  logic          wait_en_r;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_bits_r;
  logic          out_load;
  logic [2:0]    out_bits;
  logic          in_acc;
  op_t           op;
  logic          chk_wait;

  logic          hist_wr;
  logic [7:0]    hist_q;
  logic          hist_ok;
  logic [IW-1:0] hist_off;

  logic          patt_wr;
  list_t         patt_wr_sel;
  logic          patt_clear;
  list_t         patt_rd_sel;
  logic [IW-1:0] patt_addr;
  logic [8:0]    patt_q;
  logic [LW-1:0] halt_len, wait_len, scan_len;
  logic          halt_full, wait_full;

  scan_req_t     req;
  scan_rsp_t     rsp;

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign op         = op_t'(in_tuser);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_bits_r};
  assign cfg_ready  = 1'b1;
  assign scan_len   = (req.sel == LIST_WAIT) ? wait_len : halt_len;

  // command decode and check sequencer
  always_comb begin
    state_nxt   = state_r;
    running_nxt = running_r;
    waiting_nxt = waiting_r;
    out_load    = 1'b0;
    out_bits    = 3'd0;
    hist_wr     = 1'b0;
    patt_wr     = 1'b0;
    patt_wr_sel = LIST_HALT;
    patt_clear  = 1'b0;
    req.start   = 1'b0;
    req.sel     = LIST_HALT;
    chk_wait    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (op)
            OP_RX: begin
              hist_wr   = 1'b1;
              state_nxt = S_CHECK;
            end
            OP_HALTW: begin
              patt_wr     = 1'b1;
              patt_wr_sel = LIST_HALT;
              out_load    = 1'b1;
              out_bits[2] = halt_full;
            end
            OP_WAITW: begin
              patt_wr     = 1'b1;
              patt_wr_sel = LIST_WAIT;
              out_load    = 1'b1;
              out_bits[2] = wait_full;
            end
            OP_CLEAR: begin
              patt_clear = 1'b1;
              out_load   = 1'b1;
            end
            OP_START: begin
              running_nxt = 1'b1;
              waiting_nxt = wait_en_r;
              out_load    = 1'b1;
            end
            OP_STOP: begin
              running_nxt = 1'b0;
              waiting_nxt = 1'b0;
              out_load    = 1'b1;
            end
            OP_ARM: begin
              waiting_nxt = 1'b1;
              out_load    = 1'b1;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_CHECK: begin
        if (!running_r) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end else if (halt_len != '0) begin
          req.start = 1'b1;
          req.sel   = LIST_HALT;
          state_nxt = S_HSCAN;
        end else begin
          chk_wait = 1'b1;
        end
      end
      S_HSCAN: begin
        if (rsp.done) begin
          if (rsp.hit) begin
            out_load    = 1'b1;
            out_bits[0] = 1'b1;
            running_nxt = 1'b0;
            waiting_nxt = 1'b0;
            state_nxt   = S_IDLE;
          end else begin
            chk_wait = 1'b1;
          end
        end
      end
      S_WSCAN: begin
        if (rsp.done) begin
          out_load    = 1'b1;
          out_bits[1] = rsp.hit;
          if (rsp.hit) waiting_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // wait-list step after the halt list gave no match
    if (chk_wait) begin
      if (wait_en_r && waiting_r) begin
        if (wait_len == '0) begin
          out_load    = 1'b1;
          out_bits[1] = 1'b1;
          waiting_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end else begin
          req.start = 1'b1;
          req.sel   = LIST_WAIT;
          state_nxt = S_WSCAN;
        end
      end else begin
        out_load  = 1'b1;
        state_nxt = S_IDLE;
      end
    end
  end

  // output register
  assign out_valid_nxt = out_load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      running_r   <= 1'b0;
      waiting_r   <= 1'b0;
      wait_en_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      waiting_r   <= waiting_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        wait_en_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bits_r <= out_bits;
    end
  end

  pkd_hist #(
    .HISTORY_BYTES (HISTORY_BYTES),
    .PATTERN_BYTES (PATTERN_BYTES)
  ) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (hist_wr),
    .wr_byte (in_tdata[7:0]),
    .rd_off  (hist_off),
    .rd_q    (hist_q),
    .rd_ok   (hist_ok)
  );

  pkd_patt #(
    .PATTERN_BYTES (PATTERN_BYTES)
  ) u_patt (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (patt_wr),
    .wr_sel    (patt_wr_sel),
    .wr_byte   (in_tdata[7:0]),
    .wr_start  (in_tdata[8]),
    .clear     (patt_clear),
    .rd_sel    (patt_rd_sel),
    .rd_addr   (patt_addr),
    .rd_q      (patt_q),
    .halt_len  (halt_len),
    .wait_len  (wait_len),
    .halt_full (halt_full),
    .wait_full (wait_full)
  );

  pkd_match #(
    .PATTERN_BYTES (PATTERN_BYTES)
  ) u_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .len      (scan_len),
    .pat_q    (patt_q),
    .hist_q   (hist_q),
    .hist_ok  (hist_ok),
    .pat_sel  (patt_rd_sel),
    .pat_addr (patt_addr),
    .hist_off (hist_off),
    .rsp      (rsp)
  );

  // halted and proceed never come together
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("halted and proceed set in one word");

  // matcher only answers while a scan is pending
  a_rsp_state: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r == S_HSCAN || state_r == S_WSCAN))
    else $error("scan response outside a scan");

  // a halt result leaves the run stopped
  a_halt_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_bits[0]) |=> (!running_r && !waiting_r))
    else $error("run still active after halt");

  // a non-receive command yields its word on the next cycle
  a_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && op != OP_RX) |=> out_tvalid)
    else $error("command word missing");

endmodule

`default_nettype wire

// ----- tb/sv/prompt_keyword_detector_unit_tb.sv -----
// ----------------------------------------------------------------------------
// prompt_keyword_detector_unit_tb
// Self-checking bench for the prompt keyword detector. Command words are
// driven on the input stream and mirrored into a model of the line history,
// both keyword lists and the run/wait flags. Every result word is checked
// against the oldest predicted flag set. Directed commands come first, then
// a long output hold-off, random sessions (list loads, start, typed keywords,
// noise) under several idle/stall mixes and a full drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prompt_keyword_detector_unit_tb;
  import pkd_pkg::*;

  localparam int LINE_DEPTH = HISTORY_BYTES_DEF;
  localparam int KW_DEPTH   = PATTERN_BYTES_DEF;
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int RANDOM_CMDS = 1100;

  typedef logic [8:0] kw_mem_t [KW_DEPTH];

  // one result word: halted in bit 0
  typedef struct packed {
    logic list_full;
    logic proceed;
    logic halted;
  } flags_t;

  // --------------------------------------------------------------------------
  // Scoreboard: flag predictor plus queue of expected result words
  // --------------------------------------------------------------------------
  class keyword_scoreboard;
    logic [7:0] line_buf [LINE_DEPTH];
    int         line_len;
    kw_mem_t    halt_mem;
    kw_mem_t    wait_mem;
    int         halt_len;
    int         wait_len;
    bit         running;
    bit         waiting;
    bit         wait_en;
    flags_t     expected_flags[$];
    int         errors;
    int         words_checked;
    int         halts_seen;
    int         proceeds_seen;
    int         refusals_seen;

    function new();
      line_len = 0;
      halt_len = 0;
      wait_len = 0;
      running = 0;
      waiting = 0;
      wait_en = 0;
      errors = 0;
      words_checked = 0;
      halts_seen = 0;
      proceeds_seen = 0;
      refusals_seen = 0;
    endfunction

    function void set_wait_enable(bit v);
      wait_en = v;
    endfunction

    function int pending();
      return expected_flags.size();
    endfunction

    // does any keyword of the list equal the tail of the current line
    function bit list_hit(kw_mem_t mem, int len);
      int  s;
      int  e;
      int  n;
      bit  same;
      s = 0;
      while (s < len) begin
        e = s + 1;
        while (e < len && !mem[e][8]) e++;
        n = e - s;
        if (n <= line_len) begin
          same = 1;
          for (int k = 0; k < n; k++)
            if (mem[s + k][7:0] != line_buf[line_len - n + k]) same = 0;
          if (same) return 1;
        end
        s = e;
      end
      return 0;
    endfunction

    // accepted command word: update state and queue the flags it yields
    function void record_command(logic [2:0] op, logic [7:0] b, logic ws);
      flags_t f;
      f = '0;
      case (op)
        OP_RX: begin
          if (b == CH_LF || b == CH_CR || b == CH_NUL) begin
            line_len = 0;
          end else begin
            if (line_len >= LINE_DEPTH) begin
              for (int k = 0; k < LINE_DEPTH - 1; k++) line_buf[k] = line_buf[k + 1];
              line_len = LINE_DEPTH - 1;
            end
            line_buf[line_len] = b;
            line_len++;
          end
          if (running) begin
            if (halt_len > 0 && list_hit(halt_mem, halt_len)) begin
              f.halted = 1'b1;
              running = 0;
              waiting = 0;
            end else if (wait_en && waiting) begin
              if (wait_len == 0 || list_hit(wait_mem, wait_len)) begin
                f.proceed = 1'b1;
                waiting = 0;
              end
            end
          end
        end
        OP_HALTW: begin
          if (halt_len >= KW_DEPTH) begin
            f.list_full = 1'b1;
          end else begin
            halt_mem[halt_len] = {ws, b};
            halt_len++;
          end
        end
        OP_WAITW: begin
          if (wait_len >= KW_DEPTH) begin
            f.list_full = 1'b1;
          end else begin
            wait_mem[wait_len] = {ws, b};
            wait_len++;
          end
        end
        OP_CLEAR: begin
          halt_len = 0;
          wait_len = 0;
        end
        OP_START: begin
          running = 1;
          waiting = wait_en;
        end
        OP_STOP: begin
          running = 0;
          waiting = 0;
        end
        OP_ARM: waiting = 1;
        default: ;
      endcase
      expected_flags.push_back(f);
    endfunction

    // accepted result word: compare with the oldest expectation
    function void check_word(logic [7:0] w);
      flags_t f;
      if (expected_flags.size() == 0) begin
        $error("result word %02h with no command outstanding", w);
        errors++;
        return;
      end
      f = expected_flags.pop_front();
      words_checked++;
      if (w[0] !== f.halted) begin
        $error("halted: expected %0d, got %0d", f.halted, w[0]);
        errors++;
      end
      if (w[1] !== f.proceed) begin
        $error("proceed: expected %0d, got %0d", f.proceed, w[1]);
        errors++;
      end
      if (w[2] !== f.list_full) begin
        $error("list_full: expected %0d, got %0d", f.list_full, w[2]);
        errors++;
      end
      if (w[7:3] !== 5'd0) begin
        $error("pad: expected 0, got %0h", w[7:3]);
        errors++;
      end
      if (f.halted) halts_seen++;
      if (f.proceed) proceeds_seen++;
      if (f.list_full) refusals_seen++;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and DUT
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [7:0] data_byte, [8] word_start
  logic [2:0]  in_tuser;   // [2:0] opcode
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [0] halted, [1] proceed, [2] list_full
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  keyword_scoreboard book;
  logic [8:0] halt_mirror[$];
  logic [8:0] wait_mirror[$];
  int in_idle_pct;
  int out_stall_pct;
  int hold_left;
  int cmds_sent;

  prompt_keyword_detector_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #(64'd24_000_000);
    $display("FAILURE");
    $finish;
  end

  // result side: random stalls, long hold-off on request, checking
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) book.check_word(out_tdata);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drive tasks
  // --------------------------------------------------------------------------
  // offer one command word; in_tvalid stays high unless an idle gap follows
  task automatic issue_cmd(logic [2:0] op, logic [7:0] b, logic ws);
    if ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, ws, b};
    do @(posedge clk); while (!in_tready);
    book.record_command(op, b, ws);
    cmds_sent++;
  endtask

  task automatic send_rx(logic [7:0] b);
    issue_cmd(OP_RX, b, 1'($urandom_range(1)));
  endtask

  // wait until every result is back, then let the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_wait_enable(logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    book.set_wait_enable(v);
  endtask

  task automatic add_pattern(logic [2:0] op, logic [7:0] b, logic ws);
    issue_cmd(op, b, ws);
    if (op == OP_HALTW && halt_mirror.size() < KW_DEPTH) halt_mirror.push_back({ws, b});
    else if (op == OP_WAITW && wait_mirror.size() < KW_DEPTH) wait_mirror.push_back({ws, b});
  endtask

  task automatic clear_lists();
    issue_cmd(OP_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
    halt_mirror.delete();
    wait_mirror.delete();
  endtask

  // mostly a small prompt-like alphabet so keywords show up often
  function automatic logic [7:0] pick_char(bit allow_eol);
    int r;
    logic [7:0] c;
    r = $urandom_range(99);
    if (allow_eol && r < 6) begin
      case ($urandom_range(2))
        0: c = CH_LF;
        1: c = CH_CR;
        default: c = CH_NUL;
      endcase
      return c;
    end
    if (r < 12) begin
      c = 8'($urandom_range(255));
      if (!allow_eol && (c == CH_LF || c == CH_CR || c == CH_NUL)) c = "q";
      return c;
    end
    case ($urandom_range(5))
      0: c = "a";
      1: c = "b";
      2: c = ">";
      3: c = "$";
      4: c = "#";
      default: c = " ";
    endcase
    return c;
  endfunction

  task automatic load_words(logic [2:0] op, int count, int maxlen);
    int len;
    for (int w = 0; w < count; w++) begin
      len = $urandom_range(1, maxlen);
      for (int j = 0; j < len; j++)
        add_pattern(op, pick_char(1'b0), (j == 0) ? ($urandom_range(7) != 0) : 1'b0);
    end
  endtask

  // type one loaded keyword into the rx stream
  task automatic type_word(bit use_halt);
    int p;
    int e;
    logic [8:0] src[$];
    if (use_halt) src = halt_mirror;
    else src = wait_mirror;
    if (src.size() == 0) return;
    p = $urandom_range(src.size() - 1);
    while (p > 0 && !src[p][8]) p--;
    e = p + 1;
    while (e < src.size() && !src[e][8]) e++;
    for (int i = p; i < e; i++) send_rx(src[i][7:0]);
  endtask

  // one well-formed session: lists, start, typed text with keywords and noise
  task automatic run_session(bit long_line);
    int n_rx;
    int r;
    if ($urandom_range(3) == 0) begin
      drain();
      write_wait_enable(1'($urandom_range(1)));
    end
    if ($urandom_range(4) != 0) clear_lists();
    if ($urandom_range(14) == 0) begin
      // load both lists, often past capacity
      load_words(OP_HALTW, 24, 5);
      load_words(OP_WAITW, 24, 5);
    end else begin
      load_words(OP_HALTW, $urandom_range(2), 4);
      load_words(OP_WAITW, $urandom_range(2), 4);
    end
    issue_cmd(OP_START, 8'($urandom_range(255)), 1'($urandom_range(1)));
    n_rx = long_line ? $urandom_range(70, 90) : $urandom_range(8, 30);
    for (int i = 0; i < n_rx; i++) begin
      r = $urandom_range(99);
      if (r < 10 && !long_line) type_word(1'b1);
      else if (r < 24) type_word(1'b0);
      else if (r < 28) issue_cmd(OP_ARM, 8'($urandom_range(255)), 1'($urandom_range(1)));
      else if (r < 32) issue_cmd(OP_START, 8'($urandom_range(255)), 1'($urandom_range(1)));
      else if (r < 33) issue_cmd(OP_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)));
      else if (r < 35) issue_cmd(OP_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)));
      else if (r < 37) send_rx(8'($urandom_range(255)));
      else send_rx(pick_char(!long_line));
    end
    // a long line ends on a halt keyword so the dropped-byte window is checked
    if (long_line) type_word(1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int base;
    int phase;
    book = new();
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_left = 0;
    cmds_sent = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= OP_RX;
    in_tdata  <= 16'd0;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    write_wait_enable(1'b1);
    add_pattern(OP_HALTW, "x", 1'b0);   // first byte without word start
    add_pattern(OP_HALTW, "y", 1'b0);
    add_pattern(OP_HALTW, 8'hFF, 1'b1);
    add_pattern(OP_WAITW, ">", 1'b1);
    add_pattern(OP_WAITW, 8'h00, 1'b1);
    send_rx("x");                       // not running: recorded, no check
    issue_cmd(OP_START, 8'h00, 1'b0);
    send_rx("a");
    send_rx(">");                       // wait word: proceed
    issue_cmd(OP_ARM, 8'hFF, 1'b1);
    send_rx(CH_LF);                     // empty line, wait list not empty
    send_rx("y");                       // halt word longer than the line
    send_rx("x");
    send_rx("y");                       // halt
    send_rx(8'hFF);
    issue_cmd(OP_STOP, 8'h00, 1'b0);
    issue_cmd(OP_UNUSED, 8'hFF, 1'b1);
    clear_lists();
    issue_cmd(OP_START, 8'hAA, 1'b1);
    send_rx(CH_CR);                     // empty wait list fires on line end
    issue_cmd(OP_ARM, 8'h55, 1'b0);
    send_rx(CH_NUL);
    drain();
    write_wait_enable(1'b0);

    // output held off for a long stretch while commands keep coming
    hold_left = 400;
    for (int i = 0; i < 15; i++) send_rx(pick_char(1'b1));
    drain();

    // random sessions over four idle/stall mixes
    base = cmds_sent;
    while (cmds_sent - base < RANDOM_CMDS) begin
      phase = (cmds_sent - base) * 4 / RANDOM_CMDS;
      case (phase)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 85; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 85; end
        default: begin in_idle_pct = 35; out_stall_pct = 35; end
      endcase
      run_session($urandom_range(9) == 0);
    end

    drain();
    write_wait_enable(1'b1);
    in_idle_pct = 0;
    out_stall_pct = 0;
    run_session(1'b0);
    drain();
    repeat (20) @(posedge clk);
    if (book.pending() != 0) begin
      $error("%0d expected result words never arrived", book.pending());
      book.errors++;
    end

    $display("Run covered %0d commands, %0d result words checked, %0d mismatches.",
             cmds_sent, book.words_checked, book.errors);
    $display("Flags seen: %0d halts, %0d proceeds, %0d refused list writes.",
             book.halts_seen, book.proceeds_seen, book.refusals_seen);
    if (book.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
